>>> hw/rtl/bccp_pkg.sv
// ----------------------------------------------------------------------------
// bccp_pkg: shared types and constants
// Field widths, action codes and configuration indexes for the partitioner.
// ----------------------------------------------------------------------------
package bccp_pkg;

	localparam int unsigned STREAM_W = 6;
	localparam int unsigned COUNT_W  = 40;
	localparam int unsigned CMD_W    = 32;
	localparam int unsigned STORE_W  = 10;
	localparam int unsigned BLK_W    = 21;
	localparam int unsigned STT_W    = 11;
	localparam int unsigned CFG_W    = 21;
	localparam int unsigned CFG_IDX_W = 1;

	// Action codes of an input item.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_GEN  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_TOTAL  = 1'b1;

	localparam logic [BLK_W-1:0] BLOCK_LENGTH_RST = 21'd8192;
	localparam logic [STT_W-1:0] STORE_TOTAL_RST  = 11'd1;

	typedef struct packed {
		logic                action;
		logic [STREAM_W-1:0] stream_number;
		logic [COUNT_W-1:0]  entry_count;
	} in_item_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command_id;
		logic [STREAM_W-1:0] stream_out;
		logic [COUNT_W-1:0]  stream_lo;
		logic [COUNT_W-1:0]  stream_hi;
		logic [STORE_W-1:0] store_number;
		logic [COUNT_W-1:0]  store_lo;
		logic [COUNT_W-1:0]  store_hi;
		logic [COUNT_W-1:0]  global_lo;
		logic [COUNT_W-1:0]  global_hi;
	} out_item_t;

endpackage

>>> hw/rtl/bccp_stream_if.sv
// ----------------------------------------------------------------------------
// bccp_stream_if: valid/ready channel
// Carries one item of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface bccp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/block_cyclic_chunk_partitioner.sv
// ----------------------------------------------------------------------------
// block_cyclic_chunk_partitioner: block-cyclic chunk generator
// Keeps per-stream positions and deals chunks of a global index space to
// stores block by block.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  ----------+-----+---------------------------------------------------------
//  in_ch     | in  | action, stream_number, entry_count
//  out_ch    | out | command_id, stream_out, ranges in stream, store, global
//  cfg_*     | in  | write enable, index, data (block_length, store_total)
//
// A load reads the stream tables and then writes the new entry. A generate
// runs the bit-serial dividers (global index by block length, then block
// number by store count) and the 21-step serial multiply by block length
// before its result is registered.
// One item is in work at a time; the next is taken once the result has left
// the output register. A stalled output holds back the item after that one.
// Reset clears control state and the config, total and counter registers;
// the stream tables and data registers need none.
// ----------------------------------------------------------------------------
module block_cyclic_chunk_partitioner #(
	parameter int unsigned MAX_STREAMS = 64,
	parameter int unsigned INDEX_BITS  = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bccp_stream_if.sink                    in_ch,
	bccp_stream_if.source                  out_ch,
	input  logic                           cfg_we,
	input  logic [bccp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bccp_pkg::CFG_W-1:0]     cfg_data
);
	import bccp_pkg::*;

	localparam int unsigned SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int unsigned IW = INDEX_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_LOAD, ST_DIV1, ST_WAIT1, ST_DIV2, ST_WAIT2,
		ST_MUL, ST_WAIT3, ST_EMIT
	} state_t;

	state_t state_q;

	logic [BLK_W-1:0] block_length_q;
	logic [STT_W-1:0] store_total_q;
	logic [IW-1:0]    running_total_q;
	logic [CMD_W-1:0] command_counter_q;

	// Stream tables, one read and one write port each.
	logic [IW-1:0] len_mem [MAX_STREAMS];
	logic [IW-1:0] scur_mem [MAX_STREAMS];
	logic [IW-1:0] gcur_mem [MAX_STREAMS];
	logic [IW-1:0] len_rd_q, scur_rd_q, gcur_rd_q;

	logic [SW-1:0]       addr_q;
	logic [STREAM_W-1:0] stream_q;
	logic                action_q;
	logic [IW-1:0]       count_q;
	logic                wr_load_q, wr_gen_q;
	logic [IW-1:0]       len_q, avail_q;
	logic [BLK_W-1:0]    rem_blk_q;
	logic [IW-1:0]       bnum_q;
	logic [STT_W-1:0]    st_eff;
	logic                in_range;

	logic              d1_start, d1_done, d2_start, d2_done, m_start, m_done;
	logic [IW-1:0]     d1_quo, d2_quo, m_res;
	logic [BLK_W-1:0]  d1_rem;
	logic [STT_W-1:0]  d2_rem;
	logic [BLK_W-1:0]  blk_use;

	out_item_t out_q;
	logic      out_valid_q;

	assign blk_use = (block_length_q == '0) ? BLK_W'(1) : block_length_q;
	assign st_eff  = (store_total_q == '0) ? STT_W'(1) : store_total_q;
	assign in_range = (MAX_STREAMS >= 64) ? 1'b1 :
		(32'(in_ch.data.stream_number) < MAX_STREAMS);

	assign in_ch.ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= BLOCK_LENGTH_RST;
			store_total_q  <= STORE_TOTAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_LENGTH: block_length_q <= cfg_data[BLK_W-1:0];
				CFG_STORE_TOTAL:  store_total_q  <= cfg_data[STT_W-1:0];
				default: ;
			endcase
		end
	end

	// Table read and write ports.
	always_ff @(posedge clk) begin
		len_rd_q  <= len_mem[addr_q];
		scur_rd_q <= scur_mem[addr_q];
		gcur_rd_q <= gcur_mem[addr_q];
		if (wr_load_q) begin
			len_mem[addr_q]  <= count_q;
			scur_mem[addr_q] <= '0;
			gcur_mem[addr_q] <= running_total_q;
		end else if (wr_gen_q) begin
			scur_mem[addr_q] <= scur_rd_q + len_q;
			gcur_mem[addr_q] <= gcur_rd_q + len_q;
		end
	end

	// Remainder of the block after the current global position.
	logic [IW-1:0] room_c;
	logic [IW-1:0] avail_c;
	assign room_c  = IW'(blk_use) - IW'(d1_rem);
	assign avail_c = len_rd_q - scur_rd_q;

	assign d1_start = (state_q == ST_DIV1);
	assign d2_start = (state_q == ST_DIV2);
	assign m_start  = (state_q == ST_MUL);

	bccp_divider #(.W(IW), .D(BLK_W)) u_div_blk (
		.clk, .arst_n, .start(d1_start), .dividend(gcur_rd_q), .divisor(blk_use),
		.done(d1_done), .quotient(d1_quo), .remainder(d1_rem)
	);

	bccp_divider #(.W(IW), .D(STT_W)) u_div_st (
		.clk, .arst_n, .start(d2_start), .dividend(bnum_q), .divisor(st_eff),
		.done(d2_done), .quotient(d2_quo), .remainder(d2_rem)
	);

	bccp_serial_mac #(.W(IW), .B(BLK_W)) u_mac (
		.clk, .arst_n, .start(m_start), .a(d2_quo), .b(blk_use),
		.acc(IW'(rem_blk_q)), .done(m_done), .result(m_res)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			out_valid_q       <= 1'b0;
			running_total_q   <= '0;
			command_counter_q <= '0;
			wr_load_q         <= 1'b0;
			wr_gen_q          <= 1'b0;
		end else begin
			wr_load_q <= 1'b0;
			wr_gen_q  <= 1'b0;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			// The running total moves on at the edge that writes the old
			// total as the stream's global start.
			if (wr_load_q) begin
				running_total_q <= running_total_q + count_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready && in_range) begin
						addr_q   <= SW'(in_ch.data.stream_number);
						stream_q <= in_ch.data.stream_number;
						action_q <= in_ch.data.action;
						count_q  <= IW'(in_ch.data.entry_count);
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= (action_q == ACT_LOAD) ? ST_LOAD : ST_DIV1;
				end
				ST_LOAD: begin
					wr_load_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_DIV1: begin
					avail_q <= avail_c;
					state_q <= ST_WAIT1;
				end
				ST_WAIT1: begin
					if (d1_done) begin
						bnum_q    <= d1_quo;
						rem_blk_q <= d1_rem;
						len_q     <= (avail_q < room_c) ? avail_q : room_c;
						state_q   <= ((avail_q == '0)) ? ST_IDLE : ST_DIV2;
					end
				end
				ST_DIV2: state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (d2_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_WAIT3;
				ST_WAIT3: begin
					if (m_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					out_q.command_id   <= command_counter_q;
					out_q.stream_out   <= stream_q;
					out_q.stream_lo    <= COUNT_W'(scur_rd_q);
					out_q.stream_hi    <= COUNT_W'(scur_rd_q + len_q - 1'b1);
					out_q.store_number <= STORE_W'(d2_rem);
					out_q.store_lo     <= COUNT_W'(m_res);
					out_q.store_hi     <= COUNT_W'(m_res + len_q - 1'b1);
					out_q.global_lo    <= COUNT_W'(gcur_rd_q);
					out_q.global_hi    <= COUNT_W'(gcur_rd_q + len_q - 1'b1);
					out_valid_q        <= 1'b1;
					command_counter_q  <= command_counter_q + 1'b1;
					wr_gen_q           <= 1'b1;
					state_q            <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/bccp_divider.sv
// ----------------------------------------------------------------------------
// bccp_divider: bit-serial restoring divider
// Divides a W-bit dividend by a D-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bccp_divider #(
	parameter int unsigned W = 40,
	parameter int unsigned D = 21
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [D-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [D:0]    trial;
	logic [D+1:0]  diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	// The extra top bit of the difference is the borrow.
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				if (!diff[D+1]) begin
					rem_q <= diff[D-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= trial[D-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

>>> hw/rtl/bccp_serial_mac.sv
// ----------------------------------------------------------------------------
// bccp_serial_mac: shift-and-add multiply accumulate
// Computes acc + a * b with one multiplier bit per cycle, truncated to W bits.
// ----------------------------------------------------------------------------
module bccp_serial_mac #(
	parameter int unsigned W = 40,
	parameter int unsigned B = 21
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [B-1:0] b,
	input  logic [W-1:0] acc,
	output logic         done,
	output logic [W-1:0] result
);
	localparam int unsigned CW = $clog2(B + 1);

	logic [W-1:0]  a_q;
	logic [B-1:0]  b_q;
	logic [W-1:0]  sum_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	// Each step adds the shifted multiplicand when the current multiplier bit is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(B);
				a_q    <= a;
				b_q    <= b;
				sum_q  <= acc;
			end else if (busy_q) begin
				if (b_q[0]) begin
					sum_q <= sum_q + a_q;
				end
				a_q   <= {a_q[W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[B-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = sum_q;
endmodule

>>> hw/rtl/bccp_checker.sv
// ----------------------------------------------------------------------------
// bccp_checker: port-level assertions
// Watches the channels of the partitioner and checks ordering and holds.
// ----------------------------------------------------------------------------
module bccp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input bccp_pkg::out_item_t          out_data
);
	import bccp_pkg::*;

	// A held result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");

	// No new item is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item taken during result");

	// An item taken blocks the input on the next cycle.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("two items in work");

	// A result that is not taken stays offered.
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind block_cyclic_chunk_partitioner bccp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
